// ----- hw/rtl/hle_pkg.sv -----
// Shared types, codes and helpers for the heartbeat leader election core.
// No dependencies; imported by every module of the block.
package hle_pkg;

  localparam int MAX_PEERS   = 16;
  localparam int PEER_W      = $clog2(MAX_PEERS);
  localparam int CNT_W       = $clog2(MAX_PEERS + 1);
  localparam int SCORE_W     = 16;
  localparam int HB_W        = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ACT_W       = 2;

  // input action codes
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EVAL   = 2'd2;

  // classified operations handed to the back end
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_INDEX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_FLOOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_CEIL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEADER = 3'd5;

  typedef struct packed {
    logic [PEER_W-1:0]         own_index;
    logic [4:0]                peer_count;
    logic signed [SCORE_W-1:0] score_floor;
    logic signed [SCORE_W-1:0] score_ceiling;
    logic signed [SCORE_W-1:0] fail_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [PEER_W-1:0] peer;
    logic [HB_W-1:0]   heartbeat;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // peer_count limited to the store size
  function automatic logic [CNT_W-1:0] peers_in_use(input logic [4:0] pc);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_PEERS);
    if (pc > 5'(MAX_PEERS)) return lim;
    return CNT_W'(pc);
  endfunction

endpackage

// ----- hw/rtl/heartbeat_leader_election_core.sv -----
// Top level of the heartbeat failure detector with leader election.
// Holds the configuration registers; instantiates hle_front, hle_queue, hle_back.
//
// Usage: a command is taken when start is high and busy is low; each command
// yields exactly one result, shown for one cycle while done is high, and the
// receiver cannot stall it. Commands enter a two-entry queue, so busy rises only
// while two commands wait behind the one in work. An accepted command is queued
// before the back end takes it, and results are registered. A tick, undefined
// action or dropped report completes from idle; an accepted report does a
// registered read of the score and heartbeat stores, then the update; evaluate
// completes from idle when this node leads, else checks the leader's score and,
// if failed, scans peers one at a time through the single read port of the score
// store. Stores are cleared at reset through per-entry valid bits, with no
// clearing pass. cfg_ready is always high; write configuration while idle.
module heartbeat_leader_election_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [hle_pkg::ACT_W-1:0]           action,
  input  logic [hle_pkg::PEER_W-1:0]          peer,
  input  logic [hle_pkg::HB_W-1:0]            heartbeat,
  output logic                                done,
  output logic [hle_pkg::PEER_W-1:0]          leader,
  output logic                                leader_changed,
  output logic                                became_leader,
  output logic [hle_pkg::HB_W-1:0]            own_heartbeat,
  output logic signed [hle_pkg::SCORE_W-1:0]  peer_score,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hle_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hle_pkg::*;

  cfg_t   cfg;
  qstat_t qstat;
  item_t  push_item;
  item_t  head_item;
  logic   push;
  logic   pop;
  logic   cfg_we;
  logic   ld_leader;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign ld_leader = cfg_we && (cfg_index == CFG_INIT_LEADER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_index      <= '0;
      cfg.peer_count     <= 5'd16;
      cfg.score_floor    <= -SCORE_W'(8);
      cfg.score_ceiling  <= SCORE_W'(8);
      cfg.fail_threshold <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_INDEX:   cfg.own_index      <= cfg_data[PEER_W-1:0];
        CFG_PEER_COUNT:  cfg.peer_count     <= cfg_data[4:0];
        CFG_SCORE_FLOOR: cfg.score_floor    <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_CEIL:  cfg.score_ceiling  <= cfg_data[SCORE_W-1:0];
        CFG_FAIL_THRESH: cfg.fail_threshold <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  hle_front u_front (
    .start     (start),
    .action    (action),
    .peer      (peer),
    .heartbeat (heartbeat),
    .cfg       (cfg),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .item      (push_item)
  );

  hle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (head_item),
    .qstat   (qstat)
  );

  hle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .ld_leader      (ld_leader),
    .ld_value       (cfg_data[PEER_W-1:0]),
    .qstat          (qstat),
    .item           (head_item),
    .pop            (pop),
    .done           (done),
    .leader         (leader),
    .leader_changed (leader_changed),
    .became_leader  (became_leader),
    .own_heartbeat  (own_heartbeat),
    .peer_score     (peer_score)
  );

`ifndef SYNTH
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !qstat.empty)
    else $error("accepted beat did not reach the queue");

  a_change_moves: assert property (@(posedge clk) disable iff (rst)
    (done && leader_changed) |-> (leader != $past(leader)))
    else $error("leader change flagged but leader unchanged");

  a_became_implies_change: assert property (@(posedge clk) disable iff (rst)
    (done && became_leader) |-> leader_changed)
    else $error("became_leader without leader change");
`endif

endmodule

// ----- hw/rtl/hle_front.sv -----
// Front end: takes command beats and classifies them into back-end operations.
// Depends on hle_pkg.
module hle_front (
  input  logic                      start,
  input  logic [hle_pkg::ACT_W-1:0] action,
  input  logic [hle_pkg::PEER_W-1:0] peer,
  input  logic [hle_pkg::HB_W-1:0]  heartbeat,
  input  hle_pkg::cfg_t             cfg,
  input  hle_pkg::qstat_t           qstat,
  output logic                      busy,
  output logic                      push,
  output hle_pkg::item_t            item
);
  import hle_pkg::*;

  logic [CNT_W-1:0] n;

  assign n    = peers_in_use(cfg.peer_count);
  assign busy = qstat.full;
  assign push = start & ~qstat.full;

  always_comb begin
    item.peer      = peer;
    item.heartbeat = heartbeat;
    unique case (action)
      ACT_TICK:   item.op = OP_TICK;
      // reports for this node or for peers not in use are dropped here
      ACT_REPORT: item.op = (peer != cfg.own_index && {1'b0, peer} < n) ? OP_REPORT : OP_NOP;
      ACT_EVAL:   item.op = OP_EVAL;
      default:    item.op = OP_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/hle_queue.sv -----
// Short FIFO of classified operations between front and back end.
// Depends on hle_pkg.
module hle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hle_pkg::item_t  wr_item,
  input  logic            pop,
  output hle_pkg::item_t  rd_item,
  output hle_pkg::qstat_t qstat
);
  import hle_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/hle_back.sv -----
// Back end: score store, heartbeat store, own counter and leader sequencer.
// Depends on hle_pkg; fed by hle_queue.
module hle_back (
  input  logic                              clk,
  input  logic                              rst,
  input  hle_pkg::cfg_t                     cfg,
  input  logic                              ld_leader,
  input  logic [hle_pkg::PEER_W-1:0]        ld_value,
  input  hle_pkg::qstat_t                   qstat,
  input  hle_pkg::item_t                    item,
  output logic                              pop,
  output logic                              done,
  output logic [hle_pkg::PEER_W-1:0]        leader,
  output logic                              leader_changed,
  output logic                              became_leader,
  output logic [hle_pkg::HB_W-1:0]          own_heartbeat,
  output logic signed [hle_pkg::SCORE_W-1:0] peer_score
);
  import hle_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_RPT   = 3'd1;
  localparam logic [2:0] S_RPT      = 3'd2;
  localparam logic [2:0] S_RD_LDR   = 3'd3;
  localparam logic [2:0] S_LCHK     = 3'd4;
  localparam logic [2:0] S_SCAN_RD  = 3'd5;
  localparam logic [2:0] S_SCAN_CMP = 3'd6;

  logic [2:0]                state;
  logic [PEER_W-1:0]         addr;
  logic [HB_W-1:0]           w_hb;
  logic [HB_W-1:0]           own_counter;
  logic [PEER_W-1:0]         cur_leader;
  logic signed [SCORE_W-1:0] score_out;

  logic signed [SCORE_W-1:0] score_mem [MAX_PEERS];
  logic [HB_W-1:0]           hb_mem    [MAX_PEERS];
  logic [MAX_PEERS-1:0]      valid;
  logic signed [SCORE_W-1:0] rd_score;
  logic [HB_W-1:0]           rd_hb;
  logic                      rd_vld;

  logic signed [SCORE_W-1:0] eff_score;
  logic [HB_W-1:0]           eff_hb;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W:0]   lo_clamp;
  logic signed [SCORE_W:0]   hi_clamp;
  logic signed [SCORE_W-1:0] new_score;
  logic                      failed;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          limit;
  logic [CNT_W-1:0]          next_addr;
  logic [PEER_W-1:0]         pick;

  assign leader        = cur_leader;
  assign own_heartbeat = own_counter;
  assign peer_score    = score_out;
  assign pop           = (state == S_IDLE) && !qstat.empty;

  // entries never written read as zero
  assign eff_score = rd_vld ? rd_score : '0;
  assign eff_hb    = rd_vld ? rd_hb : '0;
  assign failed    = eff_score < cfg.fail_threshold;

  // floor clamp first, ceiling second: ceiling wins when they cross
  always_comb begin
    sum       = {eff_score[SCORE_W-1], eff_score} +
                ((eff_hb != w_hb) ? (SCORE_W+1)'(1) : -(SCORE_W+1)'(1));
    lo_clamp  = (sum < $signed({cfg.score_floor[SCORE_W-1], cfg.score_floor})) ?
                {cfg.score_floor[SCORE_W-1], cfg.score_floor} : sum;
    hi_clamp  = (lo_clamp > $signed({cfg.score_ceiling[SCORE_W-1], cfg.score_ceiling})) ?
                {cfg.score_ceiling[SCORE_W-1], cfg.score_ceiling} : lo_clamp;
    new_score = hi_clamp[SCORE_W-1:0];
  end

  // scan covers peers below both the count in use and own index
  assign n         = peers_in_use(cfg.peer_count);
  assign limit     = ({1'b0, cfg.own_index} < n) ? {1'b0, cfg.own_index} : n;
  assign next_addr = {1'b0, addr} + CNT_W'(1);
  assign pick      = (state == S_SCAN_CMP && !failed) ? addr : cfg.own_index;

  always_ff @(posedge clk) begin
    if (state == S_RPT) begin
      score_mem[addr] <= new_score;
      hb_mem[addr]    <= w_hb;
    end
    rd_score <= score_mem[addr];
    rd_hb    <= hb_mem[addr];
    rd_vld   <= valid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == S_RPT) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      own_counter    <= '0;
      cur_leader     <= '0;
      done           <= 1'b0;
      leader_changed <= 1'b0;
      became_leader  <= 1'b0;
      score_out      <= '0;
      addr           <= '0;
      w_hb           <= '0;
    end else begin
      done <= 1'b0;
      if (ld_leader) cur_leader <= ld_value;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            addr <= item.peer;
            w_hb <= item.heartbeat;
            unique case (item.op)
              OP_REPORT: state <= S_RD_RPT;
              OP_EVAL: begin
                if (cur_leader == cfg.own_index) begin
                  done           <= 1'b1;
                  leader_changed <= 1'b0;
                  became_leader  <= 1'b0;
                  score_out      <= '0;
                end else begin
                  addr  <= cur_leader;
                  state <= S_RD_LDR;
                end
              end
              default: begin
                if (item.op == OP_TICK) own_counter <= own_counter + 1'b1;
                done           <= 1'b1;
                leader_changed <= 1'b0;
                became_leader  <= 1'b0;
                score_out      <= '0;
              end
            endcase
          end
        end
        S_RD_RPT: state <= S_RPT;
        S_RPT: begin
          done           <= 1'b1;
          leader_changed <= 1'b0;
          became_leader  <= 1'b0;
          score_out      <= new_score;
          state          <= S_IDLE;
        end
        S_RD_LDR: state <= S_LCHK;
        S_LCHK, S_SCAN_CMP: begin
          if (state == S_LCHK && !failed) begin
            done           <= 1'b1;
            leader_changed <= 1'b0;
            became_leader  <= 1'b0;
            score_out      <= '0;
            state          <= S_IDLE;
          end else if (state == S_LCHK && limit != '0) begin
            addr  <= '0;
            state <= S_SCAN_RD;
          end else if (state == S_SCAN_CMP && failed && next_addr < limit) begin
            addr  <= next_addr[PEER_W-1:0];
            state <= S_SCAN_RD;
          end else begin
            // leader resolved: first peer that meets threshold, else this node
            done      <= 1'b1;
            score_out <= '0;
            state     <= S_IDLE;
            if (pick != cur_leader) begin
              cur_leader     <= pick;
              leader_changed <= 1'b1;
              became_leader  <= (pick == cfg.own_index);
            end else begin
              leader_changed <= 1'b0;
              became_leader  <= 1'b0;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/hle_result_checker.sv -----
// Result checker for heartbeat_leader_election_core: tracks register writes and
// accepted command beats, predicts each result and compares it. Uses hle_pkg.
module hle_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [hle_pkg::ACT_W-1:0]           action,
  input  logic [hle_pkg::PEER_W-1:0]          peer,
  input  logic [hle_pkg::HB_W-1:0]            heartbeat,
  input  logic                                done,
  input  logic [hle_pkg::PEER_W-1:0]          leader,
  input  logic                                leader_changed,
  input  logic                                became_leader,
  input  logic [hle_pkg::HB_W-1:0]            own_heartbeat,
  input  logic signed [hle_pkg::SCORE_W-1:0]  peer_score,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hle_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  results_checked,
  output int                                  leader_moves
);
  import hle_pkg::*;

  typedef struct packed {
    logic [PEER_W-1:0]         leader;
    logic                      changed;
    logic                      became;
    logic [HB_W-1:0]           own_hb;
    logic signed [SCORE_W-1:0] score;
  } election_result_t;

  election_result_t          awaited_results [$];
  logic [HB_W-1:0]           hb_seen [MAX_PEERS];
  logic signed [SCORE_W-1:0] score_of [MAX_PEERS];
  logic [HB_W-1:0]           tick_count;
  logic [PEER_W-1:0]         leader_now;
  logic [PEER_W-1:0]         self_idx;
  logic [4:0]                peers_set;
  logic signed [SCORE_W-1:0] floor_r;
  logic signed [SCORE_W-1:0] ceil_r;
  logic signed [SCORE_W-1:0] thresh_r;
  int                        mismatch_count = 0;
  int                        compared = 0;
  int                        moves = 0;

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_OWN_INDEX:   self_idx   = d[PEER_W-1:0];
      CFG_PEER_COUNT:  peers_set  = d[4:0];
      CFG_SCORE_FLOOR: floor_r    = d;
      CFG_SCORE_CEIL:  ceil_r     = d;
      CFG_FAIL_THRESH: thresh_r   = d;
      // loading the initial leader also moves the live leader
      CFG_INIT_LEADER: leader_now = d[PEER_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic election_result_t next_election_result(
      input logic [ACT_W-1:0] act, input logic [PEER_W-1:0] who, input logic [HB_W-1:0] hb);
    election_result_t r;
    int in_use;
    int s;
    int pick;
    r = '0;
    in_use = (peers_set > 5'(MAX_PEERS)) ? MAX_PEERS : int'(peers_set);
    case (act)
      ACT_TICK: tick_count = tick_count + 1'b1;
      ACT_REPORT: begin
        if (who != self_idx && int'(who) < in_use) begin
          s = int'(score_of[who]) + ((hb_seen[who] != hb) ? 1 : -1);
          // floor first, ceiling last: ceiling wins when they cross
          if (s < int'(floor_r)) s = int'(floor_r);
          if (s > int'(ceil_r)) s = int'(ceil_r);
          score_of[who] = SCORE_W'(s);
          hb_seen[who] = hb;
          r.score = SCORE_W'(s);
        end
      end
      ACT_EVAL: begin
        if (leader_now != self_idx && score_of[leader_now] < thresh_r) begin
          pick = int'(self_idx);
          for (int i = 0; i < in_use; i++)
            if (i != int'(self_idx) && score_of[i] >= thresh_r && i < pick) pick = i;
          if (pick != int'(leader_now)) begin
            leader_now = PEER_W'(pick);
            r.changed = 1'b1;
            r.became = (pick == int'(self_idx));
            moves++;
          end
        end
      end
      default: ;
    endcase
    r.leader = leader_now;
    r.own_hb = tick_count;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [HB_W-1:0] want,
                               input logic [HB_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    election_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_PEERS; i++) begin
        hb_seen[i]  = '0;
        score_of[i] = '0;
      end
      tick_count = '0;
      leader_now = '0;
      self_idx   = '0;
      peers_set  = 5'd16;
      floor_r    = -16'sd8;
      ceil_r     = 16'sd8;
      thresh_r   = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (done) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing, got leader %h hb %h",
                   $time, leader, own_heartbeat);
        end else begin
          want = awaited_results.pop_front();
          compared++;
          compare_field("leader", want.leader, leader);
          compare_field("leader_changed", want.changed, leader_changed);
          compare_field("became_leader", want.became, became_leader);
          compare_field("own_heartbeat", want.own_hb, own_heartbeat);
          compare_field("peer_score", want.score, peer_score);
        end
      end
      // a result never shows up on the beat of its own command
      if (start && !busy) awaited_results.push_back(next_election_result(action, peer, heartbeat));
    end
    errors          <= mismatch_count;
    outstanding     <= awaited_results.size();
    results_checked <= compared;
    leader_moves    <= moves;
  end

endmodule

// ----- test/tb_heartbeat_leader_election_core.sv -----
// Testbench top for heartbeat_leader_election_core: clock, reset, register setup,
// command stimulus and verdict. Depends on hle_pkg, the RTL and hle_result_checker.
module tb_heartbeat_leader_election_core;
  import hle_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_UNDEF    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;
  localparam int NUM_REGS     = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 100;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [ACT_W-1:0]            action = '0;
  logic [PEER_W-1:0]           peer = '0;
  logic [HB_W-1:0]             heartbeat = '0;
  logic                        done;
  logic [PEER_W-1:0]           leader;
  logic                        leader_changed;
  logic                        became_leader;
  logic [HB_W-1:0]             own_heartbeat;
  logic signed [SCORE_W-1:0]   peer_score;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int errors;
  int outstanding;
  int results_checked;
  int leader_moves;
  int stall_cycles = 0;
  int commands_sent = 0;
  bit gaps_on;
  logic [CFG_DATA_W-1:0] reg_val [NUM_REGS];
  logic [HB_W-1:0]       last_sent [MAX_PEERS];
  logic [MAX_PEERS-1:0]  alive;

  heartbeat_leader_election_core dut (.*);
  hle_result_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("heartbeat_leader_election_core verification failed");
      $finish;
    end
  end

  // start stays high across back-to-back beats; it only drops before a gap or in drain()
  task automatic send_cmd(input logic [ACT_W-1:0] a, input logic [PEER_W-1:0] p,
                          input logic [HB_W-1:0] hb);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    action    <= a;
    peer      <= p;
    heartbeat <= hb;
    do @(posedge clk); while (busy);
    commands_sent++;
    if (a == ACT_REPORT) last_sent[p] = hb;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_regs(input logic [NUM_REGS-1:0] mask);
    for (int i = 0; i < NUM_REGS; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= reg_val[i];
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_config(input int ph, output logic [NUM_REGS-1:0] mask);
    reg_val[CFG_OWN_INDEX]   = CFG_DATA_W'($urandom_range(0, 15));
    reg_val[CFG_PEER_COUNT]  = CFG_DATA_W'($urandom_range(2, 16));
    reg_val[CFG_SCORE_FLOOR] = CFG_DATA_W'(-int'($urandom_range(1, 5)));
    reg_val[CFG_SCORE_CEIL]  = CFG_DATA_W'($urandom_range(1, 5));
    reg_val[CFG_FAIL_THRESH] = CFG_DATA_W'(int'($urandom_range(0, 3)) - 2);
    reg_val[CFG_INIT_LEADER] = CFG_DATA_W'($urandom_range(0, 15));
    mask = '0;
    for (int i = 0; i <= int'(CFG_INIT_LEADER); i++) mask[i] = 1'b1;
    case (ph)
      0: begin
        reg_val[CFG_OWN_INDEX]   = '0;
        reg_val[CFG_PEER_COUNT]  = 16'd16;
        reg_val[CFG_SCORE_FLOOR] = 16'h8000;
        reg_val[CFG_SCORE_CEIL]  = 16'h7fff;
        reg_val[CFG_FAIL_THRESH] = 16'h8000;
      end
      1: begin
        reg_val[CFG_OWN_INDEX]   = 16'd15;
        reg_val[CFG_PEER_COUNT]  = 16'd16;
        reg_val[CFG_SCORE_FLOOR] = 16'h8000;
        reg_val[CFG_SCORE_CEIL]  = 16'h7fff;
        reg_val[CFG_FAIL_THRESH] = 16'h7fff;
      end
      2: begin
        // crossed clamps
        reg_val[CFG_SCORE_FLOOR] = 16'd3;
        reg_val[CFG_SCORE_CEIL]  = 16'hffff;
        reg_val[CFG_FAIL_THRESH] = 16'hffff;
      end
      3: for (int i = 0; i <= int'(CFG_INIT_LEADER); i++) reg_val[i] = CFG_DATA_W'($urandom);
      4: begin
        reg_val[CFG_OWN_INDEX]  = '0;
        reg_val[CFG_PEER_COUNT] = 16'd1;
      end
      5: begin
        // junk in the unused upper data bits
        reg_val[CFG_OWN_INDEX]  = 16'hfff3;
        reg_val[CFG_PEER_COUNT] = 16'hfff4;
      end
      default: if (ph % 2) mask[CFG_INIT_LEADER] = 1'b0;
    endcase
  endtask

  // mostly reports; live peers usually bring a fresh heartbeat, dead ones a stale one
  task automatic random_cmd(output bit counts);
    int r;
    int in_use;
    int span;
    logic [ACT_W-1:0]  a;
    logic [PEER_W-1:0] p;
    logic [HB_W-1:0]   hb;
    logic [PEER_W-1:0] self_idx;
    self_idx = reg_val[CFG_OWN_INDEX][PEER_W-1:0];
    in_use = (reg_val[CFG_PEER_COUNT][4:0] > 5'(MAX_PEERS)) ? MAX_PEERS :
             int'(reg_val[CFG_PEER_COUNT][4:0]);
    span = (in_use == 0) ? MAX_PEERS : in_use;
    if ($urandom_range(0, 29) == 0) alive[PEER_W'($urandom_range(0, 15))] ^= 1'b1;
    r  = $urandom_range(0, 99);
    p  = PEER_W'($urandom_range(0, 15));
    hb = {$urandom, $urandom};
    if (r < 55) begin
      a = ACT_REPORT;
      if ($urandom_range(0, 9) != 0) p = PEER_W'($urandom_range(0, span - 1));
      if (alive[p] ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 7) != 0))
        hb = last_sent[p];
      else if ($urandom_range(0, 1)) hb = last_sent[p] + 1'b1;
    end else if (r < 75) a = ACT_EVAL;
    else if (r < 95) a = ACT_TICK;
    else a = ACT_UNDEF;
    counts = (a != ACT_UNDEF) && !(a == ACT_REPORT && (p == self_idx || int'(p) >= in_use));
    send_cmd(a, p, hb);
  endtask

  initial begin
    logic [NUM_REGS-1:0] mask;
    bit counts;
    int useful;
    for (int i = 0; i < MAX_PEERS; i++) last_sent[i] = '0;
    for (int i = 0; i < NUM_REGS; i++) reg_val[i] = '0;
    reg_val[CFG_PEER_COUNT]  = 16'd16;
    reg_val[CFG_SCORE_FLOOR] = 16'hfff8;
    reg_val[CFG_SCORE_CEIL]  = 16'd8;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: this node is 0 and leads
    send_cmd(ACT_TICK, '0, '0);
    send_cmd(ACT_UNDEF, 4'd15, '1);
    send_cmd(ACT_REPORT, 4'd0, '1);
    send_cmd(ACT_REPORT, 4'd1, '0);
    send_cmd(ACT_REPORT, 4'd1, '1);
    send_cmd(ACT_REPORT, 4'd15, 64'h8000_0000_0000_0000);
    send_cmd(ACT_EVAL, '0, '0);

    // walk the failover chain down to this node
    drain();
    reg_val[CFG_OWN_INDEX]   = 16'd5;
    reg_val[CFG_INIT_LEADER] = 16'd2;
    program_regs((8'd1 << CFG_OWN_INDEX) | (8'd1 << CFG_INIT_LEADER));
    send_cmd(ACT_REPORT, 4'd2, '0);
    send_cmd(ACT_REPORT, 4'd2, '0);
    send_cmd(ACT_EVAL, '0, '0);
    send_cmd(ACT_REPORT, 4'd0, '0);
    send_cmd(ACT_EVAL, '0, '0);
    send_cmd(ACT_REPORT, 4'd1, '1);
    send_cmd(ACT_EVAL, '0, '0);
    send_cmd(ACT_REPORT, 4'd3, '0);
    send_cmd(ACT_EVAL, '0, '0);
    send_cmd(ACT_REPORT, 4'd4, '0);
    send_cmd(ACT_EVAL, '0, '0);

    // no peers in use, crossed clamps, unmapped register indexes
    drain();
    reg_val[CFG_OWN_INDEX]   = 16'd15;
    reg_val[CFG_PEER_COUNT]  = 16'd0;
    reg_val[CFG_SCORE_FLOOR] = 16'h7fff;
    reg_val[CFG_SCORE_CEIL]  = 16'h8000;
    reg_val[CFG_FAIL_THRESH] = 16'h7fff;
    reg_val[CFG_INIT_LEADER] = 16'd3;
    reg_val[CFG_UNUSED_6]    = CFG_DATA_W'($urandom);
    reg_val[CFG_UNUSED_7]    = CFG_DATA_W'($urandom);
    program_regs('1);
    send_cmd(ACT_REPORT, 4'd3, '1);
    send_cmd(ACT_EVAL, '0, '0);
    drain();
    reg_val[CFG_PEER_COUNT] = 16'd31;
    program_regs(8'd1 << CFG_PEER_COUNT);
    send_cmd(ACT_REPORT, 4'd14, '1);
    send_cmd(ACT_EVAL, '0, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      pick_config(ph, mask);
      program_regs(mask);
      alive   = MAX_PEERS'($urandom);
      gaps_on = (ph % 3) != 2;
      useful  = 0;
      while (useful < PHASE_ITEMS) begin
        random_cmd(counts);
        if (counts) useful++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d commands across %0d register setups: %0d results compared,",
             commands_sent, PHASES + 4, results_checked);
    $display("%0d leader switches predicted, %0d mismatches.", leader_moves, errors);
    if (errors == 0) begin
      $display("heartbeat_leader_election_core verification clean");
    end else begin
      $display("heartbeat_leader_election_core verification failed");
    end
    $finish;
  end

endmodule
